[hdl/kvt_pkg.sv]
// ----------------------------------------------------------------------------
// kvt_pkg
// Types and constants for the key/value text tokenizer: lexer and pairing
// modes, token and event codes, and the result record.
// ----------------------------------------------------------------------------
package kvt_pkg;

    localparam int POS_W      = 13;
    localparam int TEXT_BYTES = 8192;
    localparam int DEPTH_W    = 8;
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 3;

    localparam logic [POS_W-1:0]   POS_LIMIT         = POS_W'(TEXT_BYTES - 1);
    localparam logic [DEPTH_W-1:0] MAX_SECTION_DEPTH = DEPTH_W'(255);
    localparam logic [POS_W-1:0]   MAX_LEN_RESET     = POS_W'(127);

    localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;
    localparam logic [BYTE_W-1:0] CH_OPEN    = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_CLOSE   = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_NL      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_GRAPH_LO = 8'h21;
    localparam logic [BYTE_W-1:0] CH_GRAPH_HI = 8'h7E;

    typedef enum logic [2:0] {
        LX_BETWEEN,
        LX_QUOTE,
        LX_WORD,
        LX_SLASH,
        LX_COMMENT
    } lex_mode_t;

    typedef enum logic [1:0] {
        PM_KEY,
        PM_VALUE,
        PM_SECTION
    } pair_mode_t;

    typedef enum logic [2:0] {
        TK_STRING,
        TK_OPEN,
        TK_CLOSE,
        TK_END,
        TK_ERROR
    } tok_kind_t;

    typedef enum logic [KIND_W-1:0] {
        EV_PAIR,
        EV_END,
        EV_SYNTAX,
        EV_LONG,
        EV_DEEP
    } event_kind_t;

    typedef struct packed {
        logic             valid;
        tok_kind_t        kind;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] len;
    } token_t;

    typedef struct packed {
        pair_mode_t         mode;
        logic [POS_W-1:0]   key_start;
        logic [POS_W-1:0]   key_len;
        logic [DEPTH_W-1:0] depth;
        logic               finished;
    } pair_state_t;

    typedef struct packed {
        event_kind_t      kind;
        logic [POS_W-1:0] key_start;
        logic [POS_W-1:0] key_len;
        logic [POS_W-1:0] value_start;
        logic [POS_W-1:0] value_length;
        logic             last;
    } result_t;

    typedef struct packed {
        pair_state_t ps;
        logic        emit;
        result_t     res;
    } take_out_t;

endpackage

[hdl/keyvalue_text_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// keyvalue_text_tokenizer_core
// One text byte per beat; lexing and key/value pairing update in the cycle
// of acceptance and up to two result beats go into a four-entry result queue.
// Result beats are written into the queue as their byte is accepted; the outputs show the queue head.
// Throughput: one byte per cycle while the result queue has room for two.
// Reset: asynchronous, clears run state and queue, max_value_length to 127.
// ----------------------------------------------------------------------------
module keyvalue_text_tokenizer_core
    import kvt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                end_of_text,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [KIND_W-1:0]   event_kind,
    output logic [POS_W-1:0]    key_start,
    output logic [POS_W-1:0]    key_len,
    output logic [POS_W-1:0]    value_start,
    output logic [POS_W-1:0]    value_length,
    output logic                last_of_run,
    input  logic                cfg_we,
    input  logic [POS_W-1:0]    cfg_wdata
);

    localparam pair_state_t PAIR_RESET = '{
        mode:       PM_KEY,
        key_start:  '0,
        key_len:    '0,
        depth:      '0,
        finished:   1'b0
    };

    function automatic logic is_space(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic is_graph(input logic [BYTE_W-1:0] b);
        return (b >= CH_GRAPH_LO) && (b <= CH_GRAPH_HI);
    endfunction

    function automatic take_out_t take_token(
        input pair_state_t      ps,
        input token_t           tk,
        input logic [POS_W-1:0] max_len
    );
        take_out_t r;
        r      = '0;
        r.ps   = ps;
        r.emit = 1'b0;
        if (tk.valid && !ps.finished)
        begin
            if (tk.kind == TK_ERROR)
            begin
                r.emit     = 1'b1;
                r.res.kind = EV_SYNTAX;
            end
            else
            begin
                case (ps.mode)
                    PM_KEY:
                    begin
                        if (tk.kind == TK_STRING)
                        begin
                            r.ps.key_start = tk.start;
                            r.ps.key_len   = tk.len;
                            r.ps.mode      = PM_VALUE;
                        end
                        else if (tk.kind == TK_OPEN)
                        begin
                            r.emit     = 1'b1;
                            r.res.kind = EV_SYNTAX;
                        end
                        else
                        begin
                            r.emit     = 1'b1;
                            r.res.kind = EV_END;
                        end
                    end
                    PM_VALUE:
                    begin
                        if (tk.kind == TK_STRING)
                        begin
                            r.emit = 1'b1;
                            if (tk.len > max_len)
                            begin
                                r.res.kind = EV_LONG;
                            end
                            else
                            begin
                                r.res.kind         = EV_PAIR;
                                r.res.key_start    = ps.key_start;
                                r.res.key_len      = ps.key_len;
                                r.res.value_start  = tk.start;
                                r.res.value_length = tk.len;
                                r.ps.mode          = PM_KEY;
                            end
                        end
                        else if (tk.kind == TK_OPEN)
                        begin
                            r.ps.depth = DEPTH_W'(1);
                            r.ps.mode  = PM_SECTION;
                        end
                        else
                        begin
                            r.emit     = 1'b1;
                            r.res.kind = EV_SYNTAX;
                        end
                    end
                    default:
                    begin
                        if (tk.kind == TK_OPEN)
                        begin
                            if (ps.depth >= MAX_SECTION_DEPTH)
                            begin
                                r.emit     = 1'b1;
                                r.res.kind = EV_DEEP;
                            end
                            else
                            begin
                                r.ps.depth = ps.depth + DEPTH_W'(1);
                            end
                        end
                        else if (tk.kind == TK_CLOSE)
                        begin
                            if (ps.depth <= DEPTH_W'(1))
                            begin
                                r.ps.depth = '0;
                                r.ps.mode  = PM_KEY;
                            end
                            else
                            begin
                                r.ps.depth = ps.depth - DEPTH_W'(1);
                            end
                        end
                        else if (tk.kind == TK_END)
                        begin
                            r.emit     = 1'b1;
                            r.res.kind = EV_SYNTAX;
                        end
                    end
                endcase
            end
        end
        if (r.emit && (r.res.kind != EV_PAIR))
        begin
            r.ps.finished = 1'b1;
        end
        return r;
    endfunction

    lex_mode_t          lex_mode_reg, lex_mode_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   tok_start_reg, tok_start_next;
    pair_state_t        pair_reg, pair_next;
    logic [POS_W-1:0]   max_len_reg;

    result_t            queue_reg [4];
    logic [1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [2:0]         count_reg, count_next;

    token_t             tk_a, tk_e0, tk_e1;
    take_out_t          r0, r1, r2;
    result_t            res0, res1;
    logic [1:0]         n_res;
    logic               in_fire, out_fire;
    result_t            head;

    assign in_ready  = (count_reg <= 3'd2);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (count_reg != 3'd0);
    assign out_fire  = out_valid && out_ready;

    // lexer and pairing for the incoming byte
    always_comb
    begin
        lex_mode_t        lm1;
        logic [POS_W-1:0] ts1;
        logic             active;
        logic             over;
        lm1    = lex_mode_reg;
        ts1    = tok_start_reg;
        tk_a   = '0;
        tk_e0  = '0;
        tk_e1  = '0;
        active = !pair_reg.finished;
        over   = (pos_reg >= POS_LIMIT);

        if (active && over)
        begin
            tk_a.valid = 1'b1;
            tk_a.kind  = TK_ERROR;
        end
        else if (active)
        begin
            case (lex_mode_reg)
                LX_BETWEEN:
                begin
                    if (is_space(data_byte))
                    begin
                        lm1 = LX_BETWEEN;
                    end
                    else if (data_byte == CH_QUOTE)
                    begin
                        lm1 = LX_QUOTE;
                        ts1 = pos_reg + POS_W'(1);
                    end
                    else if (data_byte == CH_OPEN)
                    begin
                        tk_a.valid = 1'b1;
                        tk_a.kind  = TK_OPEN;
                    end
                    else if (data_byte == CH_CLOSE)
                    begin
                        tk_a.valid = 1'b1;
                        tk_a.kind  = TK_CLOSE;
                    end
                    else if (data_byte == CH_SLASH)
                    begin
                        lm1 = LX_SLASH;
                    end
                    else if (is_graph(data_byte))
                    begin
                        lm1 = LX_WORD;
                        ts1 = pos_reg;
                    end
                    else
                    begin
                        tk_a.valid = 1'b1;
                        tk_a.kind  = TK_ERROR;
                    end
                end
                LX_QUOTE:
                begin
                    if (data_byte == CH_QUOTE)
                    begin
                        lm1        = LX_BETWEEN;
                        tk_a.valid = 1'b1;
                        tk_a.kind  = TK_STRING;
                        tk_a.start = tok_start_reg;
                        tk_a.len   = pos_reg - tok_start_reg;
                    end
                end
                LX_WORD:
                begin
                    if (!is_graph(data_byte))
                    begin
                        lm1        = LX_BETWEEN;
                        tk_a.valid = 1'b1;
                        tk_a.kind  = TK_STRING;
                        tk_a.start = tok_start_reg;
                        tk_a.len   = pos_reg - tok_start_reg;
                    end
                end
                LX_SLASH:
                begin
                    if (data_byte == CH_SLASH)
                    begin
                        lm1 = LX_COMMENT;
                    end
                    else
                    begin
                        lm1        = LX_BETWEEN;
                        tk_a.valid = 1'b1;
                        tk_a.kind  = TK_ERROR;
                    end
                end
                default:
                begin
                    if (data_byte == CH_NL)
                    begin
                        lm1 = LX_BETWEEN;
                    end
                end
            endcase

            // end of text closes an open word and ends the run; an open quote or slash is an error
            if (end_of_text)
            begin
                tk_e0.valid = 1'b1;
                case (lm1)
                    LX_WORD:
                    begin
                        tk_e0.kind  = TK_STRING;
                        tk_e0.start = ts1;
                        tk_e0.len   = pos_reg + POS_W'(1) - ts1;
                        tk_e1.valid = 1'b1;
                        tk_e1.kind  = TK_END;
                    end
                    LX_QUOTE, LX_SLASH:
                    begin
                        tk_e0.kind = TK_ERROR;
                    end
                    default:
                    begin
                        tk_e0.kind = TK_END;
                    end
                endcase
            end
        end

        r0 = take_token(pair_reg, tk_a, max_len_reg);
        r1 = take_token(r0.ps, tk_e0, max_len_reg);
        r2 = take_token(r1.ps, tk_e1, max_len_reg);

        n_res = 2'(r0.emit) + 2'(r1.emit) + 2'(r2.emit);
        if (r0.emit)
        begin
            res0 = r0.res;
            res1 = r1.emit ? r1.res : r2.res;
        end
        else
        begin
            res0 = r1.emit ? r1.res : r2.res;
            res1 = r2.res;
        end
        res0.last = (n_res == 2'd1);
        res1.last = 1'b1;

        lex_mode_next  = lex_mode_reg;
        pos_next       = pos_reg;
        tok_start_next = tok_start_reg;
        pair_next      = r2.ps;
        if (active && !over)
        begin
            lex_mode_next  = lm1;
            tok_start_next = ts1;
            pos_next       = pos_reg + POS_W'(1);
        end
        if (end_of_text)
        begin
            lex_mode_next  = LX_BETWEEN;
            pos_next       = '0;
            tok_start_next = '0;
            pair_next      = PAIR_RESET;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (in_fire)
        begin
            count_next = count_next + 3'(n_res);
        end
        if (out_fire)
        begin
            count_next = count_next - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_mode_reg  <= LX_BETWEEN;
            pos_reg       <= '0;
            tok_start_reg <= '0;
            pair_reg      <= PAIR_RESET;
            max_len_reg   <= MAX_LEN_RESET;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                lex_mode_reg  <= lex_mode_next;
                pos_reg       <= pos_next;
                tok_start_reg <= tok_start_next;
                pair_reg      <= pair_next;
                wr_ptr_reg    <= wr_ptr_reg + n_res;
            end
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
            if (out_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    // result queue payload
    always_ff @(posedge clk)
    begin
        if (in_fire && (n_res != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (in_fire && (n_res == 2'd2))
        begin
            queue_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    assign head         = queue_reg[rd_ptr_reg];
    assign event_kind   = head.kind;
    assign key_start    = head.key_start;
    assign key_len      = head.key_len;
    assign value_start  = head.value_start;
    assign value_length = head.value_length;
    assign last_of_run  = head.last;

endmodule
